[rtl/gcd_pkg.sv]
// shared constants, types and helper functions for the great-circle distance pipeline
package gcd_pkg;

  localparam int CORDIC_STEPS    = 24;
  localparam int ANGLE_FRAC_BITS = 23;
  localparam int SQRT_STEPS      = 31;

  localparam logic [23:0] RADIUS_RESET = 24'd6371000;
  localparam logic signed [35:0] CORDIC_K = 36'sd652032874;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [29:0] DIST_MAX = 30'h3FFF_FFFF;
  localparam logic [61:0] ONE_Q60 = 62'h1000_0000_0000_0000;

  // degree modulus; the binary angle is 64*(r/45) + (64*(r%45) + 22)/45
  localparam logic [33:0] DEG_MOD = 34'd360 << ANGLE_FRAC_BITS;

  // reciprocals of 45: exact for 32-bit and for 12-bit dividends
  localparam logic [32:0] RECIP45       = 33'd6108397933;
  localparam logic [12:0] RECIP45_SMALL = 13'd5826;

  typedef logic signed [35:0] cw_t;   // cordic word
  typedef logic signed [33:0] zw_t;   // cordic angle accumulator

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2E;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // quotient by 45 of a reduced angle (below 360*2^F)
  function automatic logic [25:0] div45(input logic [31:0] r);
    logic [64:0] p;
    p = 65'(r) * 65'(RECIP45);
    return 26'(p >> 38);
  endfunction

  // reduced angle r = 45*h + l -> binary angle 64*h + (64*l + 22)/45
  function automatic logic [31:0] to_turns(input logic [31:0] r, input logic [25:0] h);
    logic [31:0] l;
    logic [11:0] n;
    logic [24:0] g;
    l = r - ({6'd0, h} * 32'd45);
    n = {l[5:0], 6'd0} + 12'd22;
    g = 25'(n) * 25'(RECIP45_SMALL);
    return {h, 6'd0} + {26'd0, g[23:18]};
  endfunction

endpackage

[rtl/great_circle_distance_top.sv]
// great-circle (haversine) distance pipeline, one point pair per cycle
//
// usage: drive lat_a, lon_a, lat_b, lon_b and pulse start; busy is always low,
// so a word is taken at every cycle that start is high. distance appears with
// done high for exactly one cycle once the pair has passed the stage chain:
// 5 front stages (differences, reduction modulo 360, quotient by 45,
// binary-angle assembly, cosine/sine setup), 24 rotation cordic stages,
// 5 stages for a (4 multiply stages and the clamp), 31 square-root stages,
// 24 vectoring cordic stages, and 4 scaling stages.
// the rate is set by the stage chain: one pair per cycle, one result per pair.
// the radius register is written through cfg_valid/cfg_ready/cfg_data; ready is
// always high and the write takes effect at once (write only while idle).
// reset (rst, synchronous) clears all valid bits and loads the earth radius;
// data in flight is dropped. the receiver cannot stall; results are never held.
module great_circle_distance_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data,
  output logic               done,
  output logic [29:0]        distance
);

  localparam int NS = gcd_pkg::CORDIC_STEPS;
  localparam int NQ = gcd_pkg::SQRT_STEPS;

  logic [23:0] radius;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  // ---------------- front stages ----------------
  // f0: differences
  logic        v0;
  logic signed [32:0] dlat0, dlon0;
  logic signed [30:0] la0, lb0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    dlat0 <= 33'(lat_b) - 33'(lat_a);
    dlon0 <= 33'(lon_b) - 33'(lon_a);
    la0 <= lat_a;
    lb0 <= lat_b;
  end

  // f1: modulo 360 (values within two moduli below zero and one above)
  function automatic logic [31:0] wrap360(input logic signed [32:0] d);
    logic signed [34:0] r;
    logic signed [34:0] m;
    m = 35'(gcd_pkg::DEG_MOD);
    r = 35'(d);
    if (r < -m) r = r + m + m;
    else if (r < 0) r = r + m;
    else if (r >= m) r = r - m;
    return 32'(r);
  endfunction

  logic v1;
  logic [31:0] r1 [4];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    r1[0] <= wrap360(dlat0);
    r1[1] <= wrap360(dlon0);
    r1[2] <= wrap360(33'(la0));
    r1[3] <= wrap360(33'(lb0));
  end

  // fq: quotient of each reduced angle by 45
  logic vq;
  logic [31:0] rq [4];
  logic [25:0] hq [4];
  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else vq <= v1;
    for (int k = 0; k < 4; k++) begin
      rq[k] <= r1[k];
      hq[k] <= gcd_pkg::div45(r1[k]);
    end
  end

  // f2: binary angle
  logic v2;
  logic [31:0] u2 [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= vq;
    for (int k = 0; k < 4; k++) u2[k] <= gcd_pkg::to_turns(rq[k], hq[k]);
  end

  // f3: start angles for four rotations; cos lanes fold into the right half
  logic v3;
  gcd_pkg::zw_t z3 [4];
  logic flip3 [2];
  always_ff @(posedge clk) begin
    logic [31:0] u;
    logic f;
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    for (int k = 0; k < 2; k++) begin
      z3[k] <= 34'($signed(u2[k])) >>> 1;
    end
    for (int k = 0; k < 2; k++) begin
      u = u2[k+2];
      f = (u >= 32'h4000_0000) && (u < 32'hC000_0000);
      if (f) u = u + 32'h8000_0000;
      flip3[k] <= f;
      z3[k+2] <= 34'($signed(u));
    end
  end

  // ---------------- rotation cordic, four lanes ----------------
  gcd_pkg::cw_t rx [NS+1][4];
  gcd_pkg::cw_t ry [NS+1][4];
  gcd_pkg::zw_t rz [NS+1][4];
  logic         rf [NS+1][2];
  logic         rv [NS+1];

  always_comb begin
    rv[0] = v3;
    for (int k = 0; k < 4; k++) begin
      rx[0][k] = gcd_pkg::CORDIC_K;
      ry[0][k] = '0;
      rz[0][k] = z3[k];
    end
    rf[0][0] = flip3[0];
    rf[0][1] = flip3[1];
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      gcd_pkg::zw_t t;
      if (rst) rv[i+1] <= 1'b0;
      else rv[i+1] <= rv[i];
      t = 34'(gcd_pkg::atan_turn(i));
      for (int k = 0; k < 4; k++) begin
        if (!rz[i][k][33]) begin
          rx[i+1][k] <= rx[i][k] - (ry[i][k] >>> (i % 32));
          ry[i+1][k] <= ry[i][k] + (rx[i][k] >>> (i % 32));
          rz[i+1][k] <= rz[i][k] - t;
        end else begin
          rx[i+1][k] <= rx[i][k] + (ry[i][k] >>> (i % 32));
          ry[i+1][k] <= ry[i][k] - (rx[i][k] >>> (i % 32));
          rz[i+1][k] <= rz[i][k] + t;
        end
      end
      rf[i+1] <= rf[i];
    end
  end

  // ---------------- a = s1^2 + ((ca*cb>>30)*s2>>30)*s2 ----------------
  // cordic outputs stay within about 2^30, so 33-bit operands hold them
  logic v4, v5, v6, v7;
  logic signed [32:0] s1_4, s2_4, ca4, cb4;
  logic signed [65:0] s1sq5, s1sq6, s1sq7;
  logic signed [32:0] c12_5, s2_5, s2_6;
  logic signed [65:0] m6;
  logic signed [65:0] m7;
  logic [61:0] a7;

  always_ff @(posedge clk) begin
    logic signed [32:0] t6;
    if (rst) begin
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v4 <= rv[NS]; v5 <= v4; v6 <= v5; v7 <= v6;
    end
    s1_4 <= 33'(ry[NS][0]);
    s2_4 <= 33'(ry[NS][1]);
    ca4  <= rf[NS][0] ? 33'(-rx[NS][2]) : 33'(rx[NS][2]);
    cb4  <= rf[NS][1] ? 33'(-rx[NS][3]) : 33'(rx[NS][3]);
    s1sq5 <= s1_4 * s1_4;
    c12_5 <= 33'((66'(ca4) * 66'(cb4)) >>> 30);
    s2_5  <= s2_4;
    s1sq6 <= s1sq5;
    m6    <= c12_5 * s2_5;
    s2_6  <= s2_5;
    s1sq7 <= s1sq6;
    t6    = 33'(m6 >>> 30);
    m7    <= t6 * s2_6;
  end

  // clamp into 0..2^60
  logic v8;
  logic [61:0] a8;
  always_comb begin
    logic signed [66:0] s;
    s = 67'(s1sq7) + 67'(m7);
    if (s < 0) a7 = '0;
    else if (s > $signed(67'(gcd_pkg::ONE_Q60))) a7 = gcd_pkg::ONE_Q60;
    else a7 = 62'(s);
  end
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else v8 <= v7;
    a8 <= a7;
  end

  // ---------------- two square roots, one bit pair per stage ----------------
  logic [61:0] qn [NQ+1][2];
  logic [61:0] qr [NQ+1][2];
  logic        qv [NQ+1];
  always_comb begin
    qv[0] = v8;
    qn[0][0] = a8;
    qn[0][1] = gcd_pkg::ONE_Q60 - a8;
    qr[0][0] = '0;
    qr[0][1] = '0;
  end
  for (genvar i = 0; i < NQ; i++) begin : g_sqrt
    localparam logic [61:0] B = 62'd1 << (60 - 2 * i);
    always_ff @(posedge clk) begin
      if (rst) qv[i+1] <= 1'b0;
      else qv[i+1] <= qv[i];
      for (int k = 0; k < 2; k++) begin
        if (qn[i][k] >= qr[i][k] + B) begin
          qn[i+1][k] <= qn[i][k] - (qr[i][k] + B);
          qr[i+1][k] <= (qr[i][k] >> 1) + B;
        end else begin
          qn[i+1][k] <= qn[i][k];
          qr[i+1][k] <= qr[i][k] >> 1;
        end
      end
    end
  end

  // ---------------- vectoring cordic ----------------
  gcd_pkg::cw_t vx [NS+1];
  gcd_pkg::cw_t vy [NS+1];
  gcd_pkg::zw_t vz [NS+1];
  logic         vv [NS+1];
  always_comb begin
    vv[0] = qv[NQ];
    vy[0] = 36'(qr[NQ][0]);
    vx[0] = 36'(qr[NQ][1]);
    vz[0] = '0;
  end
  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      gcd_pkg::zw_t t;
      if (rst) vv[i+1] <= 1'b0;
      else vv[i+1] <= vv[i];
      t = 34'(gcd_pkg::atan_turn(i));
      if (vy[i] > 0) begin
        vx[i+1] <= vx[i] + (vy[i] >>> (i % 32));
        vy[i+1] <= vy[i] - (vx[i] >>> (i % 32));
        vz[i+1] <= vz[i] + t;
      end else begin
        vx[i+1] <= vx[i] - (vy[i] >>> (i % 32));
        vy[i+1] <= vy[i] + (vx[i] >>> (i % 32));
        vz[i+1] <= vz[i] - t;
      end
    end
  end

  // ---------------- scaling ----------------
  logic v9, v10, v11, v12;
  logic [30:0] z9;
  logic [62:0] p10;
  logic [38:0] u11;
  logic [62:0] d12;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
    end else begin
      v9 <= vv[NS]; v10 <= v9; v11 <= v10; v12 <= v11;
    end
    if (vz[NS] < 0) z9 <= '0;
    else if (vz[NS] > 34'sd1073741824) z9 <= 31'd1073741824;
    else z9 <= 31'(vz[NS]);
    p10 <= 63'(z9) * 63'(gcd_pkg::PI_Q30);
    u11 <= 39'(p10 >> 24);
    d12 <= 63'((64'(radius) * 64'(u11) + 64'h8000_0000) >> 32);
  end

  assign done = v12;
  assign distance = (d12 > 63'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : d12[29:0];

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
      v0 |-> ##92 done)
    else $error("result missing after fixed latency");
  a_a_range: assert property (@(posedge clk) disable iff (rst)
      v8 |-> (a8 <= gcd_pkg::ONE_Q60))
    else $error("a out of range");
  a_sat: assert property (@(posedge clk) disable iff (rst)
      done |-> (distance <= gcd_pkg::DIST_MAX))
    else $error("distance above maximum");
`endif

endmodule
